// ===== rtl/core/pttr_pkg.sv =====
// ----------------------------------------------------------------------------
// pttr_pkg
// Shared types and constants for the page table translate/reverse block.
// ----------------------------------------------------------------------------
package pttr_pkg;

    // fixed field widths of the request and response beats
    localparam int ADDR_W        = 20;
    localparam int MODE_W        = 2;
    localparam int IDX_FIELD_W   = 6;
    localparam int FRAME_FIELD_W = 10;
    localparam int CFG_W         = 7;

    // parameter defaults
    localparam int OFFSET_BITS_DEF = 10;
    localparam int MAX_PAGES_DEF   = 64;
    localparam int FRAME_BITS_DEF  = 10;

    // configuration port
    localparam int             CFG_ADDR_W       = 3;
    localparam int             CFG_DATA_W       = 32;
    localparam logic           REG_PAGES_IN_USE = 1'b0;
    localparam logic [CFG_W-1:0] PAGES_RESET    = 7'd64;

    // request modes
    localparam logic [MODE_W-1:0] MODE_WRITE = 2'd0;
    localparam logic [MODE_W-1:0] MODE_FWD   = 2'd1;
    localparam logic [MODE_W-1:0] MODE_REV   = 2'd2;

    typedef struct packed {
        logic [MODE_W-1:0]        mode;
        logic [ADDR_W-1:0]        address;
        logic [IDX_FIELD_W-1:0]   entry_index;
        logic [FRAME_FIELD_W-1:0] entry_frame;
    } req_t;

    typedef struct packed {
        logic [ADDR_W-1:0] result_address;
        logic              fault;
    } rsp_t;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_DISPATCH,
        ST_FWD_DATA,
        ST_SCAN,
        ST_FINISH
    } state_t;

    typedef enum logic [1:0] {
        RES_ZERO,
        RES_FAULT,
        RES_FWD,
        RES_REV
    } res_sel_t;

    typedef enum logic [1:0] {
        RADDR_PAGE,
        RADDR_ZERO,
        RADDR_NEXT
    } raddr_sel_t;

    typedef struct packed {
        logic       item_load;
        logic       mem_we;
        logic       we_clear;
        raddr_sel_t raddr_sel;
        logic       cnt_clr;
        logic       cnt_inc;
        logic       res_load;
        res_sel_t   res_sel;
        logic       out_load;
    } ctrl_cmd_t;

    typedef struct packed {
        logic [MODE_W-1:0] mode;
        logic              page_oor;
        logic              n_zero;
        logic              idx_ok;
        logic              match;
        logic              scan_last;
        logic              clr_last;
    } ctrl_sts_t;

endpackage

// ===== rtl/core/page_table_translate_and_reverse.sv =====
// ----------------------------------------------------------------------------
// page_table_translate_and_reverse
// Single-level page table: entry write, forward and reverse translation.
// ----------------------------------------------------------------------------
//  channel  | handshake              | payload
//  ---------+------------------------+-------------------------------------
//  req      | req_valid / req_ready  | mode, address, entry_index, frame
//  rsp      | rsp_valid / rsp_ready  | result_address, fault
//  config   | APB psel/penable/...   | pages_in_use at byte address 0
//
//  After reset the frame table is cleared, one entry per cycle, over all
//  MAX_PAGES entries; no request beat is taken meanwhile.
//  The output register is loaded from the result register. Writes, faults and
//  the unused mode load the result at dispatch, forward hits after the table
//  read, and reverse lookups after a scan of up to n entries, n being the
//  saturated page count: the scan reads one table entry per cycle through the
//  single RAM read port. The next beat is taken after the output load.
//  A result waiting in the output register does not block the next accept.
// ----------------------------------------------------------------------------
module page_table_translate_and_reverse #(
    parameter int OFFSET_BITS = pttr_pkg::OFFSET_BITS_DEF,
    parameter int MAX_PAGES   = pttr_pkg::MAX_PAGES_DEF,
    parameter int FRAME_BITS  = pttr_pkg::FRAME_BITS_DEF
) (
    input  logic                                clk,
    input  logic                                rst_n,

    input  logic                                req_valid,
    output logic                                req_ready,
    input  pttr_pkg::req_t                      req,

    output logic                                rsp_valid,
    input  logic                                rsp_ready,
    output pttr_pkg::rsp_t                      rsp,

    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [pttr_pkg::CFG_ADDR_W-1:0]     paddr,
    input  logic [pttr_pkg::CFG_DATA_W-1:0]     pwdata,
    output logic [pttr_pkg::CFG_DATA_W-1:0]     prdata,
    output logic                                pready
);

    logic [pttr_pkg::CFG_W-1:0] pages_reg;
    logic [pttr_pkg::CFG_W-1:0] pages_next;
    logic                       reg_sel;
    pttr_pkg::ctrl_cmd_t        cmd;
    pttr_pkg::ctrl_sts_t        sts;

    assign pready  = 1'b1;
    assign reg_sel = paddr[2] == pttr_pkg::REG_PAGES_IN_USE;

    always_comb
    begin
        pages_next = pages_reg;
        if (psel && penable && pwrite && reg_sel)
        begin
            pages_next = pwdata[pttr_pkg::CFG_W-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pages_reg <= pttr_pkg::PAGES_RESET;
        end
        else
        begin
            pages_reg <= pages_next;
        end
    end

    assign prdata = reg_sel ? pttr_pkg::CFG_DATA_W'(pages_reg) : '0;

    pttr_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_ready (req_ready),
        .rsp_valid (rsp_valid),
        .rsp_ready (rsp_ready),
        .cmd       (cmd),
        .sts       (sts)
    );

    pttr_datapath #(
        .OFFSET_BITS (OFFSET_BITS),
        .MAX_PAGES   (MAX_PAGES),
        .FRAME_BITS  (FRAME_BITS)
    ) u_datapath (
        .clk          (clk),
        .rst_n        (rst_n),
        .req          (req),
        .pages_in_use (pages_reg),
        .cmd          (cmd),
        .sts          (sts),
        .rsp          (rsp)
    );

endmodule

// ===== rtl/core/pttr_ram.sv =====
// ----------------------------------------------------------------------------
// pttr_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module pttr_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [0:DEPTH-1];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// ===== rtl/core/pttr_datapath.sv =====
// ----------------------------------------------------------------------------
// pttr_datapath
// Item registers, frame table, scan counter, result and output registers.
// ----------------------------------------------------------------------------
module pttr_datapath #(
    parameter int OFFSET_BITS = pttr_pkg::OFFSET_BITS_DEF,
    parameter int MAX_PAGES   = pttr_pkg::MAX_PAGES_DEF,
    parameter int FRAME_BITS  = pttr_pkg::FRAME_BITS_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  pttr_pkg::req_t                req,
    input  logic [pttr_pkg::CFG_W-1:0]    pages_in_use,
    input  pttr_pkg::ctrl_cmd_t           cmd,
    output pttr_pkg::ctrl_sts_t           sts,
    output pttr_pkg::rsp_t                rsp
);

    localparam int ADDR_W  = pttr_pkg::ADDR_W;
    localparam int IDX_W   = (MAX_PAGES > 1) ? $clog2(MAX_PAGES) : 1;
    localparam int N_LOG   = $clog2(MAX_PAGES + 1);
    localparam int N_W     = (N_LOG > pttr_pkg::CFG_W) ? N_LOG : pttr_pkg::CFG_W;
    localparam int PF_W    = ADDR_W - OFFSET_BITS;
    localparam int CMP_W   = (PF_W > N_W) ? PF_W : N_W;
    localparam int MW      = (PF_W > FRAME_BITS) ? PF_W : FRAME_BITS;
    localparam int IW_W    = (pttr_pkg::IDX_FIELD_W > N_W) ? pttr_pkg::IDX_FIELD_W : N_W;
    localparam int FW_W    = (pttr_pkg::FRAME_FIELD_W > FRAME_BITS) ?
                             pttr_pkg::FRAME_FIELD_W : FRAME_BITS;
    localparam int CAT_A   = (FRAME_BITS + OFFSET_BITS > ADDR_W) ?
                             FRAME_BITS + OFFSET_BITS : ADDR_W;
    localparam int CAT_W   = (IDX_W + OFFSET_BITS > CAT_A) ? IDX_W + OFFSET_BITS : CAT_A;

    pttr_pkg::req_t         item_reg;
    logic [IDX_W-1:0]       cnt_reg;
    logic [IDX_W-1:0]       cnt_next;
    logic [ADDR_W-1:0]      res_reg;
    logic [ADDR_W-1:0]      res_next;
    logic                   flt_reg;
    logic                   flt_next;
    pttr_pkg::rsp_t         out_reg;

    logic [N_W-1:0]         n_pages;
    logic [PF_W-1:0]        page_or_frame;
    logic [OFFSET_BITS-1:0] offset;
    logic [CMP_W-1:0]       page_ext;
    logic [IW_W-1:0]        idx_ext;
    logic [FW_W-1:0]        frame_ext;
    logic [N_W-1:0]         cnt_plus;

    logic                   ram_we;
    logic [IDX_W-1:0]       ram_waddr;
    logic [FRAME_BITS-1:0]  ram_wdata;
    logic [IDX_W-1:0]       ram_raddr;
    logic [FRAME_BITS-1:0]  ram_rdata;

    logic [CAT_W-1:0]       fwd_cat;
    logic [CAT_W-1:0]       rev_cat;

    // saturate the configured count to the table depth
    always_comb
    begin
        if (N_W'(pages_in_use) > N_W'(MAX_PAGES))
        begin
            n_pages = N_W'(MAX_PAGES);
        end
        else
        begin
            n_pages = N_W'(pages_in_use);
        end
    end

    assign page_or_frame = item_reg.address[ADDR_W-1:OFFSET_BITS];
    assign offset        = item_reg.address[OFFSET_BITS-1:0];
    assign page_ext      = CMP_W'(page_or_frame);
    assign idx_ext       = IW_W'(item_reg.entry_index);
    assign frame_ext     = FW_W'(item_reg.entry_frame);
    assign cnt_plus      = N_W'(cnt_reg) + N_W'(1);

    assign sts.mode      = item_reg.mode;
    assign sts.page_oor  = page_ext >= CMP_W'(n_pages);
    assign sts.n_zero    = n_pages == '0;
    assign sts.idx_ok    = idx_ext < IW_W'(MAX_PAGES);
    assign sts.match     = MW'(ram_rdata) == MW'(page_or_frame);
    assign sts.scan_last = cnt_plus == n_pages;
    assign sts.clr_last  = cnt_reg == IDX_W'(MAX_PAGES - 1);

    // table port muxing
    assign ram_we    = cmd.mem_we;
    assign ram_waddr = cmd.we_clear ? cnt_reg : idx_ext[IDX_W-1:0];
    assign ram_wdata = cmd.we_clear ? '0 : frame_ext[FRAME_BITS-1:0];

    always_comb
    begin
        unique case (cmd.raddr_sel)
            pttr_pkg::RADDR_PAGE: ram_raddr = page_ext[IDX_W-1:0];
            pttr_pkg::RADDR_ZERO: ram_raddr = '0;
            pttr_pkg::RADDR_NEXT: ram_raddr = cnt_plus[IDX_W-1:0];
            default:              ram_raddr = '0;
        endcase
    end

    pttr_ram #(
        .WIDTH (FRAME_BITS),
        .DEPTH (MAX_PAGES),
        .AW    (IDX_W)
    ) u_table (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // sweep / scan counter
    always_comb
    begin
        priority if (cmd.cnt_clr)
        begin
            cnt_next = '0;
        end
        else if (cmd.cnt_inc)
        begin
            cnt_next = cnt_plus[IDX_W-1:0];
        end
        else
        begin
            cnt_next = cnt_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= '0;
        end
        else
        begin
            cnt_reg <= cnt_next;
        end
    end

    // result formatting; wraps to the address width
    assign fwd_cat = CAT_W'({ram_rdata, offset});
    assign rev_cat = CAT_W'({cnt_reg, offset});

    always_comb
    begin
        unique case (cmd.res_sel)
            pttr_pkg::RES_ZERO:
            begin
                res_next = '0;
                flt_next = 1'b0;
            end
            pttr_pkg::RES_FAULT:
            begin
                res_next = '0;
                flt_next = 1'b1;
            end
            pttr_pkg::RES_FWD:
            begin
                res_next = fwd_cat[ADDR_W-1:0];
                flt_next = 1'b0;
            end
            pttr_pkg::RES_REV:
            begin
                res_next = rev_cat[ADDR_W-1:0];
                flt_next = 1'b0;
            end
            default:
            begin
                res_next = '0;
                flt_next = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (cmd.item_load)
        begin
            item_reg <= req;
        end
        if (cmd.res_load)
        begin
            res_reg <= res_next;
            flt_reg <= flt_next;
        end
        if (cmd.out_load)
        begin
            out_reg.result_address <= res_reg;
            out_reg.fault          <= flt_reg;
        end
    end

    assign rsp = out_reg;

endmodule

// ===== rtl/core/pttr_ctrl.sv =====
// ----------------------------------------------------------------------------
// pttr_ctrl
// Sequencer: table clear after reset, item dispatch, reverse scan, handoff.
// ----------------------------------------------------------------------------
module pttr_ctrl (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                req_valid,
    output logic                req_ready,
    output logic                rsp_valid,
    input  logic                rsp_ready,
    output pttr_pkg::ctrl_cmd_t cmd,
    input  pttr_pkg::ctrl_sts_t sts
);

    pttr_pkg::state_t state_reg;
    pttr_pkg::state_t state_next;
    logic             out_valid_reg;
    logic             out_valid_next;
    logic             out_free;

    assign out_free  = !out_valid_reg || rsp_ready;
    assign req_ready = state_reg == pttr_pkg::ST_IDLE;
    assign rsp_valid = out_valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= pttr_pkg::ST_CLEAR;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_comb
    begin
        state_next    = state_reg;
        cmd           = '0;
        cmd.raddr_sel = pttr_pkg::RADDR_PAGE;
        cmd.res_sel   = pttr_pkg::RES_ZERO;

        unique case (state_reg)
            pttr_pkg::ST_CLEAR:
            begin
                cmd.mem_we   = 1'b1;
                cmd.we_clear = 1'b1;
                if (sts.clr_last)
                begin
                    cmd.cnt_clr = 1'b1;
                    state_next  = pttr_pkg::ST_IDLE;
                end
                else
                begin
                    cmd.cnt_inc = 1'b1;
                end
            end
            pttr_pkg::ST_IDLE:
            begin
                if (req_valid)
                begin
                    cmd.item_load = 1'b1;
                    state_next    = pttr_pkg::ST_DISPATCH;
                end
            end
            pttr_pkg::ST_DISPATCH:
            begin
                cmd.res_load = 1'b1;
                state_next   = pttr_pkg::ST_FINISH;
                unique case (sts.mode)
                    pttr_pkg::MODE_WRITE:
                    begin
                        cmd.mem_we = sts.idx_ok;
                    end
                    pttr_pkg::MODE_FWD:
                    begin
                        if (sts.page_oor)
                        begin
                            cmd.res_sel = pttr_pkg::RES_FAULT;
                        end
                        else
                        begin
                            cmd.res_load = 1'b0;
                            state_next   = pttr_pkg::ST_FWD_DATA;
                        end
                    end
                    pttr_pkg::MODE_REV:
                    begin
                        if (sts.n_zero)
                        begin
                            cmd.res_sel = pttr_pkg::RES_FAULT;
                        end
                        else
                        begin
                            cmd.res_load  = 1'b0;
                            cmd.raddr_sel = pttr_pkg::RADDR_ZERO;
                            cmd.cnt_clr   = 1'b1;
                            state_next    = pttr_pkg::ST_SCAN;
                        end
                    end
                    default:
                    begin
                        cmd.res_sel = pttr_pkg::RES_ZERO;
                    end
                endcase
            end
            pttr_pkg::ST_FWD_DATA:
            begin
                cmd.res_load = 1'b1;
                cmd.res_sel  = pttr_pkg::RES_FWD;
                state_next   = pttr_pkg::ST_FINISH;
            end
            pttr_pkg::ST_SCAN:
            begin
                // read data in this cycle belongs to the entry at the counter
                priority if (sts.match)
                begin
                    cmd.res_load = 1'b1;
                    cmd.res_sel  = pttr_pkg::RES_REV;
                    state_next   = pttr_pkg::ST_FINISH;
                end
                else if (sts.scan_last)
                begin
                    cmd.res_load = 1'b1;
                    cmd.res_sel  = pttr_pkg::RES_FAULT;
                    state_next   = pttr_pkg::ST_FINISH;
                end
                else
                begin
                    cmd.raddr_sel = pttr_pkg::RADDR_NEXT;
                    cmd.cnt_inc   = 1'b1;
                end
            end
            pttr_pkg::ST_FINISH:
            begin
                if (out_free)
                begin
                    cmd.out_load = 1'b1;
                    state_next   = pttr_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = pttr_pkg::ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        priority if (cmd.out_load)
        begin
            out_valid_next = 1'b1;
        end
        else if (rsp_ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

endmodule
